// ----- hw/rtl/l2c_pkg.sv -----
// Shared types, constants and character-mapping functions of the transliterator.
package l2c_pkg;

    localparam int MAX_RESULTS = 36;
    localparam int RES_AW      = $clog2(MAX_RESULTS);
    localparam int RES_CW      = $clog2(MAX_RESULTS + 1);
    localparam int UNIT_W      = 18;

    localparam logic [7:0] APOS_ASCII = 8'h27;
    localparam logic [7:0] APOS_LEAD2 = 8'hCA;
    localparam logic [7:0] APOS_MOD_T = 8'hBB;
    localparam logic [7:0] APOS_MOD_A = 8'hBC;
    localparam logic [7:0] APOS_LEAD3 = 8'hE2;
    localparam logic [7:0] APOS_MID3  = 8'h80;
    localparam logic [7:0] APOS_LQ    = 8'h98;
    localparam logic [7:0] APOS_RQ    = 8'h99;

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOP, S_SCAN, S_SCONT, S_TRANS, S_SECOND, S_FLUSH, S_RD, S_OUT, S_END
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic scan_cont;
        logic translate;
        logic write_second;
        logic write_empty;
        logic read_unit;
        logic next_unit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic ended;
        logic win_empty;
        logic stop_zero;
        logic look_ok;
        logic has_second;
        logic scan_fin;
        logic scan_fail;
        logic scan_go_cont;
        logic res_zero;
        logic last_unit;
    } t_stat;

    function automatic logic is_up(input logic [7:0] b);
        return (b >= 8'h41) && (b <= 8'h5A);
    endfunction

    function automatic logic is_latin(input logic [7:0] b);
        return is_up(b) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic [7:0] to_low(input logic [7:0] b);
        return is_up(b) ? (b + 8'h20) : b;
    endfunction

    function automatic logic [10:0] lookalike_cp(input logic [7:0] b);
        logic [10:0] cp;
        case (b)
            8'h61, 8'h41: cp = 11'h430;
            8'h42:        cp = 11'h432;
            8'h63, 8'h43: cp = 11'h441;
            8'h65, 8'h45: cp = 11'h435;
            8'h48:        cp = 11'h43D;
            8'h6B, 8'h4B: cp = 11'h43A;
            8'h6D, 8'h4D: cp = 11'h43C;
            8'h6F, 8'h4F: cp = 11'h43E;
            8'h70, 8'h50: cp = 11'h440;
            8'h54:        cp = 11'h442;
            8'h78, 8'h58: cp = 11'h445;
            8'h79, 8'h59: cp = 11'h443;
            default:      cp = 11'h000;
        endcase
        return cp;
    endfunction

    function automatic logic [15:0] cp_bytes(input logic [10:0] cp);
        return {3'b110, cp[10:6], 2'b10, cp[5:0]};
    endfunction

    // Upper-case form of a two-byte Cyrillic letter when up is set, else the letter as given.
    function automatic logic [15:0] cyr_case(input logic [15:0] u, input logic up);
        logic [15:0] r;
        r = u;
        if (up) begin
            if (u[15:8] == 8'hD0 && u[7:0] >= 8'hB0) begin
                r = {8'hD0, u[7:0] - 8'h20};
            end else if (u[15:8] == 8'hD1 && u[7:0] <= 8'h8F) begin
                r = {8'hD0, u[7:0] + 8'h20};
            end else if (u[15:8] == 8'hD1 && u[7:0] == 8'h91) begin
                r = 16'hD081;
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] single_map(input logic [7:0] lc);
        logic [15:0] r;
        case (lc)
            8'h61: r = 16'hD0B0;  8'h62: r = 16'hD0B1;  8'h63: r = 16'hD0BA;
            8'h64: r = 16'hD0B4;  8'h65: r = 16'hD0B5;  8'h66: r = 16'hD184;
            8'h67: r = 16'hD0B3;  8'h68: r = 16'hD185;  8'h69: r = 16'hD0B8;
            8'h6A: r = 16'hD0B4;  8'h6B: r = 16'hD0BA;  8'h6C: r = 16'hD0BB;
            8'h6D: r = 16'hD0BC;  8'h6E: r = 16'hD0BD;  8'h6F: r = 16'hD0BE;
            8'h70: r = 16'hD0BF;  8'h71: r = 16'hD0BA;  8'h72: r = 16'hD180;
            8'h73: r = 16'hD181;  8'h74: r = 16'hD182;  8'h75: r = 16'hD183;
            8'h76: r = 16'hD0B2;  8'h77: r = 16'hD0B2;  8'h78: r = 16'hD0BA;
            8'h79: r = 16'hD0B9;  8'h7A: r = 16'hD0B7;
            default: r = 16'hD0B0;
        endcase
        return r;
    endfunction

    // Length of an apostrophe starting at b0; av is the number of bytes present (capped at 3).
    function automatic logic [1:0] apos_len(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [1:0] av);
        logic [1:0] r;
        r = 2'd0;
        if (av != 2'd0) begin
            if (b0 == APOS_ASCII) begin
                r = 2'd1;
            end else if (av >= 2'd2 && b0 == APOS_LEAD2 &&
                         (b1 == APOS_MOD_T || b1 == APOS_MOD_A)) begin
                r = 2'd2;
            end else if (av == 2'd3 && b0 == APOS_LEAD3 && b1 == APOS_MID3 &&
                         (b2 == APOS_LQ || b2 == APOS_RQ)) begin
                r = 2'd3;
            end
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/l2c_in_if.sv -----
// Input byte channel: valid/ready with the byte and its end-of-string flag.
interface l2c_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_end;

    modport source (output valid, output in_byte, output string_end, input ready);
    modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

// ----- hw/rtl/l2c_out_if.sv -----
// Output unit channel: valid/ready with one Cyrillic or pass-through unit.
interface l2c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] byte_count;
    logic       run_end;
    logic       string_done;
    logic       token_overflow;

    modport source (output valid, output first_byte, output second_byte, output byte_count,
                    output run_end, output string_done, output token_overflow, input ready);
    modport sink   (input valid, input first_byte, input second_byte, input byte_count,
                    input run_end, input string_done, input token_overflow, output ready);
endinterface

// ----- hw/rtl/latin_to_cyrillic_transliterator_core.sv -----
// Top level of the Latin-to-Cyrillic name transliterator.
//
// Input channel i_in takes one UTF-8 byte per transfer with string_end on the
// last byte. Output channel o_out gives one unit per transfer: one passed-through
// byte, one two-byte Cyrillic letter or, at a string end that left no other
// unit, an empty unit; run_end on the last unit caused by an input byte,
// string_done on the last unit of the string.
// Each input byte is handled on its own. The accepting cycle loads it, then the
// sequencer walks the byte window: a window check, a token scan over each Latin
// and each two-byte Cyrillic letter with a closing step, the translation of each
// letter plus a write of any second unit, a flush, and for each unit in the unit
// buffer RAM a read and an offer, then a closing step.
// While a token is still open every new byte rescans it from its head (up to
// MAX_TOKEN bytes); a string end flushes the whole window. A new byte is
// taken only after all units of the previous one have been transferred.
// Reset (synchronous, active low) empties the window and the buffer. A stalled
// receiver holds the current unit steady until it is taken.
module latin_to_cyrillic_transliterator_core import l2c_pkg::*; #(
    parameter int MAX_TOKEN    = 16,
    parameter int WINDOW_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    l2c_in_if.sink    i_in,
    l2c_out_if.source o_out
);
    t_cmd  cmd;
    t_stat stat;

    l2c_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    l2c_dp #(.MAX_TOKEN(MAX_TOKEN), .WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_byte        (i_in.in_byte),
        .i_string_end     (i_in.string_end),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_first_byte     (o_out.first_byte),
        .o_second_byte    (o_out.second_byte),
        .o_byte_count     (o_out.byte_count),
        .o_run_end        (o_out.run_end),
        .o_string_done    (o_out.string_done),
        .o_token_overflow (o_out.token_overflow)
    );

`ifndef SYNTH
    // no byte is taken while a unit is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while a unit is pending");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second byte taken before the first was handled");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.string_done) |-> o_out.run_end)
        else $error("string_done without run_end");

    a_empty_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.byte_count == CNT_EMPTY) |-> o_out.string_done)
        else $error("empty unit outside a string end");
`endif
endmodule

// ----- hw/rtl/l2c_ram.sv -----
// Generic single-port-write, registered-read RAM.
module l2c_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ----- hw/rtl/l2c_dp.sv -----
// Datapath: byte window, token scanner, translation logic and unit buffer.
module l2c_dp import l2c_pkg::*; #(
    parameter int MAX_TOKEN    = 16,
    parameter int WINDOW_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_in_byte,
    input  logic       i_string_end,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    output logic [7:0] o_first_byte,
    output logic [7:0] o_second_byte,
    output logic [1:0] o_byte_count,
    output logic       o_run_end,
    output logic       o_string_done,
    output logic       o_token_overflow
);
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int TW = $clog2(MAX_TOKEN + 1);
    localparam int PW = ((CW > TW) ? CW : TW) + 1;

    logic [7:0]        r_win [WINDOW_DEPTH];
    logic [CW-1:0]     r_cnt, r_stop, r_sp;
    logic              r_head_start, r_visual, r_ovf, r_ended, r_all;
    logic [TW-1:0]     r_lat, r_cyr;
    logic [7:0]        r_lead;
    logic [15:0]       r_u2;
    logic [RES_CW-1:0] r_nres, r_rd;

    // window taps
    logic [7:0] w0, w1, w2, w3, lc, nl, nl2;
    logic       nge2, nge3, nge4, up, up2, h_next;
    logic [1:0] av0, av1, ap0, ap1;
    logic [15:0] dg, ogv;
    logic        y_hit, dg_hit, og_hit;
    logic [15:0] yv;
    logic [2:0]  tr_k;
    logic        tr_u1v, tr_has2;
    logic [UNIT_W-1:0] tr_unit;
    logic [15:0] tr_u2;

    assign w0 = r_win[0];
    assign w1 = r_win[1];
    assign w2 = r_win[2];
    assign w3 = r_win[3];
    assign nge2 = r_cnt >= CW'(2);
    assign nge3 = r_cnt >= CW'(3);
    assign nge4 = r_cnt >= CW'(4);

    always_comb begin
        lc  = to_low(w0);
        nl  = to_low(w1);
        nl2 = to_low(w2);
        up  = is_up(w0);
        up2 = up && nge2 && is_up(w1);
        av0 = nge3 ? 2'd3 : r_cnt[1:0];
        av1 = nge4 ? 2'd3 : (nge2 ? 2'(r_cnt[1:0] - 2'd1) : 2'd0);
        ap0 = apos_len(w0, w1, w2, av0);
        ap1 = apos_len(w1, w2, w3, av1);
        h_next = nge3 && (nl2 == 8'h68);

        y_hit = nge2 && (lc == 8'h79) &&
                (nl == 8'h61 || nl == 8'h75 || nl == 8'h6F || nl == 8'h65);
        case (nl)
            8'h61:   yv = 16'hD18F;
            8'h75:   yv = 16'hD18E;
            8'h6F:   yv = 16'hD191;
            default: yv = 16'hD0B5;
        endcase

        dg = 16'h0000;
        if (lc == 8'h74 && nl == 8'h73 && !h_next) begin
            dg = 16'hD186;
        end else if (nl == 8'h68) begin
            case (lc)
                8'h6B:   dg = 16'hD185;
                8'h67:   dg = 16'hD0B3;
                8'h7A:   dg = 16'hD0B6;
                8'h63:   dg = 16'hD187;
                8'h73:   dg = 16'hD188;
                default: dg = 16'h0000;
            endcase
        end else if (lc == 8'h6F && nl == 8'h6F) begin
            dg = 16'hD183;
        end else if (lc == 8'h65 && nl == 8'h65) begin
            dg = 16'hD0B8;
        end
        dg_hit = nge2 && (dg != 16'h0000);
        og_hit = (lc == 8'h6F || lc == 8'h67) && (ap1 != 2'd0);
        ogv    = (lc == 8'h6F) ? 16'hD183 : 16'hD0B3;

        tr_k    = 3'd1;
        tr_u1v  = 1'b1;
        tr_has2 = 1'b0;
        tr_u2   = 16'h0000;
        tr_unit = {w0, 8'h00, CNT_ONE};
        if (!is_latin(w0)) begin
            if (ap0 != 2'd0) begin
                tr_k   = {1'b0, ap0};
                tr_u1v = 1'b0;
            end
        end else if (r_visual) begin
            tr_unit = {cyr_case(cp_bytes(lookalike_cp(w0)), up), CNT_TWO};
        end else if (lc == 8'h78 && r_head_start) begin
            tr_unit = {cyr_case(16'hD185, up), CNT_TWO};
        end else if (y_hit) begin
            tr_unit = {cyr_case(yv, up), CNT_TWO};
            tr_k    = 3'd2;
        end else if (dg_hit) begin
            tr_unit = {cyr_case(dg, up), CNT_TWO};
            tr_k    = 3'd2;
        end else if (og_hit) begin
            tr_unit = {cyr_case(ogv, up), CNT_TWO};
            tr_k    = 3'd1 + {1'b0, ap1};
        end else begin
            tr_unit = {cyr_case(single_map(lc), up), CNT_TWO};
            if (lc == 8'h6A) begin
                tr_has2 = 1'b1;
                tr_u2   = cyr_case(16'hD0B6, up2);
            end else if (lc == 8'h78) begin
                tr_has2 = 1'b1;
                tr_u2   = cyr_case(16'hD181, up2);
            end
        end
    end

    // token scanner, one byte per step
    logic [AW-1:0] sc_addr;
    logic [7:0]    sb;
    logic [PW-1:0] sp_w;
    logic [10:0]   sc_cp;
    logic          sc_fin, sc_fail, sc_cut, sc_cont, sc_adv1, sc_adv2, cyr_ok;

    assign sc_addr = i_cmd.scan_cont ? AW'(r_sp + CW'(1)) : r_sp[AW-1:0];
    assign sb      = r_win[sc_addr];
    assign sp_w    = PW'(r_sp);
    assign sc_cp   = {r_lead[4:0], sb[5:0]};
    assign cyr_ok  = (sb[7:6] == 2'b10) &&
                     ((sc_cp >= 11'h400 && sc_cp <= 11'h481) ||
                      (sc_cp >= 11'h48A && sc_cp <= 11'h4FF));

    always_comb begin
        sc_fin  = 1'b0;
        sc_fail = 1'b0;
        sc_cut  = 1'b0;
        sc_cont = 1'b0;
        sc_adv1 = 1'b0;
        sc_adv2 = 1'b0;
        if (i_cmd.scan_cont) begin
            if (cyr_ok) begin
                if (sp_w + PW'(2) > PW'(MAX_TOKEN)) begin
                    sc_fin = 1'b1;
                    sc_cut = 1'b1;
                end else begin
                    sc_adv2 = 1'b1;
                end
            end else begin
                sc_fin = 1'b1;
            end
        end else if (r_sp >= r_cnt) begin
            if (r_ended) begin
                sc_fin = 1'b1;
            end else if (r_cnt == CW'(WINDOW_DEPTH)) begin
                sc_fin = 1'b1;
                sc_cut = 1'b1;
            end else begin
                sc_fail = 1'b1;
            end
        end else if (is_latin(sb)) begin
            if (sp_w + PW'(1) > PW'(MAX_TOKEN)) begin
                sc_fin = 1'b1;
                sc_cut = 1'b1;
            end else begin
                sc_adv1 = 1'b1;
            end
        end else if (sb >= 8'hD0 && sb <= 8'hD3) begin
            if (sp_w + PW'(1) >= PW'(r_cnt)) begin
                if (!r_ended && r_cnt < CW'(WINDOW_DEPTH)) begin
                    sc_fail = 1'b1;
                end else begin
                    sc_fin = 1'b1;
                end
            end else begin
                sc_cont = 1'b1;
            end
        end else begin
            sc_fin = 1'b1;
        end
    end

    // window storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_cnt < CW'(WINDOW_DEPTH)) begin
            r_win[r_cnt[AW-1:0]] <= i_in_byte;
        end else if (i_cmd.translate) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                case (tr_k)
                    3'd1: if (i + 1 < WINDOW_DEPTH) r_win[i] <= r_win[i + 1];
                    3'd2: if (i + 2 < WINDOW_DEPTH) r_win[i] <= r_win[i + 2];
                    3'd3: if (i + 3 < WINDOW_DEPTH) r_win[i] <= r_win[i + 3];
                    3'd4: if (i + 4 < WINDOW_DEPTH) r_win[i] <= r_win[i + 4];
                    default: ;
                endcase
            end
        end
    end

    // unit buffer
    logic              ram_we;
    logic [UNIT_W-1:0] ram_wd, ram_rd;

    always_comb begin
        ram_wd = '0;
        ram_we = 1'b0;
        if (i_cmd.translate) begin
            ram_wd = tr_unit;
            ram_we = tr_u1v;
        end else if (i_cmd.write_second) begin
            ram_wd = {r_u2, CNT_TWO};
            ram_we = 1'b1;
        end else if (i_cmd.write_empty) begin
            ram_wd = {8'h00, 8'h00, CNT_EMPTY};
            ram_we = 1'b1;
        end
        ram_we = ram_we && (r_nres < RES_CW'(MAX_RESULTS));
    end

    l2c_ram #(.WIDTH(UNIT_W), .DEPTH(MAX_RESULTS)) u_units (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_nres[RES_AW-1:0]),
        .i_wdata (ram_wd),
        .i_re    (i_cmd.read_unit),
        .i_raddr (r_rd[RES_AW-1:0]),
        .o_rdata (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_stop       <= '0;
            r_head_start <= 1'b0;
            r_visual     <= 1'b0;
            r_ovf        <= 1'b0;
            r_ended      <= 1'b0;
            r_nres       <= '0;
            r_rd         <= '0;
        end else begin
            if (i_cmd.load) begin
                r_ended <= i_string_end;
                if (r_cnt < CW'(WINDOW_DEPTH)) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
            if (i_cmd.translate) begin
                r_cnt        <= r_cnt - CW'(tr_k);
                r_stop       <= (r_stop > CW'(tr_k)) ? (r_stop - CW'(tr_k)) : '0;
                r_head_start <= 1'b0;
            end
            if (i_cmd.scan_step && sc_fin) begin
                r_stop       <= r_sp;
                r_visual     <= (r_lat != '0) && (r_cyr >= r_lat) && r_all;
                r_head_start <= 1'b1;
                if (sc_cut) begin
                    r_ovf <= 1'b1;
                end
            end
            if (ram_we) begin
                r_nres <= r_nres + RES_CW'(1);
            end
            if (i_cmd.next_unit) begin
                r_rd <= r_rd + RES_CW'(1);
            end
            if (i_cmd.finish) begin
                r_nres <= '0;
                r_rd   <= '0;
                if (r_nres != '0) begin
                    r_ovf <= 1'b0;
                end
                if (r_ended) begin
                    r_cnt        <= '0;
                    r_stop       <= '0;
                    r_head_start <= 1'b0;
                    r_visual     <= 1'b0;
                    r_ovf        <= 1'b0;
                    r_ended      <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.translate) begin
            r_u2 <= tr_u2;
        end
        if (i_cmd.scan_init) begin
            r_sp  <= '0;
            r_lat <= '0;
            r_cyr <= '0;
            r_all <= 1'b1;
        end else if (i_cmd.scan_step) begin
            if (sc_adv1) begin
                r_sp  <= r_sp + CW'(1);
                r_lat <= r_lat + TW'(1);
                if (lookalike_cp(sb) == 11'h000) begin
                    r_all <= 1'b0;
                end
            end else if (sc_adv2) begin
                r_sp  <= r_sp + CW'(2);
                r_cyr <= r_cyr + TW'(1);
            end else if (sc_cont) begin
                r_lead <= sb;
            end
        end
    end

    always_comb begin
        o_stat.ended        = r_ended;
        o_stat.win_empty    = (r_cnt == '0);
        o_stat.stop_zero    = (r_stop == '0);
        o_stat.look_ok      = r_ended || nge4;
        o_stat.has_second   = tr_has2;
        o_stat.scan_fin     = sc_fin;
        o_stat.scan_fail    = sc_fail;
        o_stat.scan_go_cont = sc_cont;
        o_stat.res_zero     = (r_nres == '0);
        o_stat.last_unit    = (r_rd == r_nres - RES_CW'(1));
    end

    assign o_first_byte     = ram_rd[17:10];
    assign o_second_byte    = ram_rd[9:2];
    assign o_byte_count     = ram_rd[1:0];
    assign o_run_end        = o_stat.last_unit;
    assign o_string_done    = o_stat.last_unit && r_ended;
    assign o_token_overflow = r_ovf;
endmodule

// ----- hw/rtl/l2c_ctrl.sv -----
// Controller: sequences load, token scan, translation and unit drain per input byte.
module l2c_ctrl import l2c_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOOP;
            end
            S_LOOP: begin
                if (i_stat.win_empty)      n_state = S_FLUSH;
                else if (i_stat.stop_zero) n_state = S_SCAN;
                else if (!i_stat.look_ok)  n_state = S_FLUSH;
                else if (i_stat.has_second) n_state = S_SECOND;
            end
            S_TRANS: begin
                if (!i_stat.look_ok)        n_state = S_FLUSH;
                else if (i_stat.has_second) n_state = S_SECOND;
                else                        n_state = S_LOOP;
            end
            S_SCAN: begin
                if (i_stat.scan_fail)         n_state = S_FLUSH;
                else if (i_stat.scan_fin)     n_state = S_TRANS;
                else if (i_stat.scan_go_cont) n_state = S_SCONT;
            end
            S_SCONT: begin
                n_state = i_stat.scan_fin ? S_TRANS : S_SCAN;
            end
            S_SECOND: n_state = S_LOOP;
            S_FLUSH: begin
                n_state = (i_stat.res_zero && !i_stat.ended) ? S_END : S_RD;
            end
            S_RD: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = i_stat.last_unit ? S_END : S_RD;
            end
            S_END: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_LOOP: begin
                if (!i_stat.win_empty) begin
                    if (i_stat.stop_zero) o_cmd.scan_init = 1'b1;
                    else                  o_cmd.translate = i_stat.look_ok;
                end
            end
            S_TRANS: o_cmd.translate = i_stat.look_ok;
            S_SCAN:  o_cmd.scan_step = 1'b1;
            S_SCONT: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.scan_cont = 1'b1;
            end
            S_SECOND: o_cmd.write_second = 1'b1;
            S_FLUSH:  o_cmd.write_empty = i_stat.res_zero && i_stat.ended;
            S_RD:     o_cmd.read_unit = 1'b1;
            S_OUT: begin
                o_out_valid     = 1'b1;
                o_cmd.next_unit = i_out_ready && !i_stat.last_unit;
            end
            S_END: o_cmd.finish = 1'b1;
            default: ;
        endcase
    end
endmodule

// ----- sim/l2c_tb_checker.sv -----
// Checker of the transliterator: predicts the units of every input transfer and compares them.
module l2c_tb_checker import l2c_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    l2c_in_if    i_in,
    l2c_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int TOK_MAX = 16;
    localparam int WIN_MAX = 32;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [1:0] byte_count;
        logic       run_end;
        logic       string_done;
        logic       token_overflow;
    } t_unit;

    localparam logic [15:0] SINGLE_TBL [26] = '{
        16'hD0B0, 16'hD0B1, 16'hD0BA, 16'hD0B4, 16'hD0B5, 16'hD184, 16'hD0B3,
        16'hD185, 16'hD0B8, 16'hD0B4, 16'hD0BA, 16'hD0BB, 16'hD0BC, 16'hD0BD,
        16'hD0BE, 16'hD0BF, 16'hD0BA, 16'hD180, 16'hD181, 16'hD182, 16'hD183,
        16'hD0B2, 16'hD0B2, 16'hD0BA, 16'hD0B9, 16'hD0B7};

    logic [7:0] win_bytes [WIN_MAX];
    int         win_fill;
    int         tok_start;
    int         tok_stop;
    int         lat_n;
    int         cyr_n;
    bit         all_look;
    bit         visual;
    bit         start_gone;
    bit         ovf_pending;
    t_unit      step_units [$];
    t_unit      exp_units [$];
    int         fails;

    function automatic bit up_letter(input logic [7:0] b);
        return b >= "A" && b <= "Z";
    endfunction

    function automatic bit latin_letter(input logic [7:0] b);
        return up_letter(b) || (b >= "a" && b <= "z");
    endfunction

    function automatic logic [7:0] low_letter(input logic [7:0] b);
        return up_letter(b) ? b + 8'h20 : b;
    endfunction

    function automatic logic [10:0] twin_cp(input logic [7:0] b);
        case (b)
            "a", "A": return 11'h430;
            "B":      return 11'h432;
            "c", "C": return 11'h441;
            "e", "E": return 11'h435;
            "H":      return 11'h43D;
            "k", "K": return 11'h43A;
            "m", "M": return 11'h43C;
            "o", "O": return 11'h43E;
            "p", "P": return 11'h440;
            "T":      return 11'h442;
            "x", "X": return 11'h445;
            "y", "Y": return 11'h443;
            default:  return 11'h000;
        endcase
    endfunction

    task automatic clear_model();
        win_fill    = 0;
        tok_start   = 0;
        tok_stop    = 0;
        lat_n       = 0;
        cyr_n       = 0;
        all_look    = 1'b1;
        visual      = 1'b0;
        start_gone  = 1'b0;
        ovf_pending = 1'b0;
    endtask

    task automatic emit(input logic [7:0] a, input logic [7:0] b, input logic [1:0] c);
        t_unit u;
        if (step_units.size() < MAX_RESULTS) begin
            u = '0;
            u.first_byte  = a;
            u.second_byte = (c == CNT_TWO) ? b : 8'h00;
            u.byte_count  = c;
            step_units.push_back(u);
        end
    endtask

    task automatic emit_letter(input logic [7:0] b0, input logic [7:0] b1, input bit up);
        logic [7:0] h;
        logic [7:0] l;
        h = b0;
        l = b1;
        if (up) begin
            if (h == 8'hD0 && l >= 8'hB0) begin
                l = l - 8'h20;
            end else if (h == 8'hD1 && l <= 8'h8F) begin
                h = 8'hD0;
                l = l + 8'h20;
            end else if (h == 8'hD1 && l == 8'h91) begin
                h = 8'hD0;
                l = 8'h81;
            end
        end
        emit(h, l, CNT_TWO);
    endtask

    task automatic emit_cp(input logic [10:0] cp, input bit up);
        emit_letter({3'b110, cp[10:6]}, {2'b10, cp[5:0]}, up);
    endtask

    function automatic int apos_at(input int p, input int n);
        logic [7:0] b;
        if (p >= n) return 0;
        b = win_bytes[p];
        if (b == APOS_ASCII) return 1;
        if (p + 1 < n && b == APOS_LEAD2 &&
            (win_bytes[p + 1] == APOS_MOD_T || win_bytes[p + 1] == APOS_MOD_A)) return 2;
        if (p + 2 < n && b == APOS_LEAD3 && win_bytes[p + 1] == APOS_MID3 &&
            (win_bytes[p + 2] == APOS_LQ || win_bytes[p + 2] == APOS_RQ)) return 3;
        return 0;
    endfunction

    // Scans the token at si; 0 while its end is still unknown.
    function automatic bit scan_token(input int si, input bit ended);
        int         p;
        int         w;
        int         lat;
        int         cyr;
        bit         all;
        bit         cut;
        logic [7:0] b;
        logic [10:0] cp;
        p   = si;
        lat = 0;
        cyr = 0;
        all = 1'b1;
        cut = 1'b0;
        forever begin
            w = 0;
            if (p >= win_fill) begin
                if (ended) break;
                if (win_fill >= WIN_MAX) begin
                    cut = 1'b1;
                    break;
                end
                return 1'b0;
            end
            b = win_bytes[p];
            if (latin_letter(b)) begin
                w = 1;
            end else if (b >= 8'hD0 && b <= 8'hD3) begin
                if (p + 1 >= win_fill) begin
                    if (!ended && win_fill < WIN_MAX) return 1'b0;
                end else if (win_bytes[p + 1][7:6] == 2'b10) begin
                    cp = {b[4:0], win_bytes[p + 1][5:0]};
                    if ((cp >= 11'h400 && cp <= 11'h481) || (cp >= 11'h48A && cp <= 11'h4FF))
                        w = 2;
                end
            end
            if (w == 0) break;
            if (p - si + w > TOK_MAX) begin
                cut = 1'b1;
                break;
            end
            if (w == 1) begin
                lat++;
                if (twin_cp(b) == 0) all = 1'b0;
            end else begin
                cyr++;
            end
            p += w;
        end
        lat_n      = lat;
        cyr_n      = cyr;
        all_look   = all;
        visual     = lat > 0 && cyr >= lat && all;
        tok_start  = si;
        tok_stop   = p;
        start_gone = 1'b0;
        if (cut) ovf_pending = 1'b1;
        return 1'b1;
    endfunction

    task automatic translate_window(input bit ended);
        int         n;
        int         si;
        int         ap;
        int         k;
        logic [7:0] b;
        logic [7:0] lc;
        logic [7:0] nl;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [15:0] sm;
        bit         up;
        bit         up2;
        bit         h_next;
        n  = win_fill;
        si = 0;
        while (si < n) begin
            if (si >= tok_stop && !scan_token(si, ended)) break;
            if (!ended && si + 3 >= n) break;
            b  = win_bytes[si];
            up = up_letter(b);
            if (!latin_letter(b)) begin
                ap = apos_at(si, n);
                if (ap != 0) begin
                    si += ap;
                    continue;
                end
                emit(b, 8'h00, CNT_ONE);
                si++;
                continue;
            end
            lc = low_letter(b);
            if (visual) begin
                emit_cp(twin_cp(b), up);
                si++;
                continue;
            end
            if (lc == "x" && si == tok_start && !start_gone) begin
                emit_letter(8'hD1, 8'h85, up);
                si++;
                continue;
            end
            if (si + 1 < n) begin
                nl = low_letter(win_bytes[si + 1]);
                if (lc == "y" && (nl == "a" || nl == "u" || nl == "o" || nl == "e")) begin
                    emit_cp(nl == "a" ? 11'h44F : nl == "u" ? 11'h44E :
                            nl == "o" ? 11'h451 : 11'h435, up);
                    si += 2;
                    continue;
                end
                h_next = si + 2 < n && low_letter(win_bytes[si + 2]) == "h";
                c0 = 8'h00;
                c1 = 8'h00;
                if (lc == "t" && nl == "s" && !h_next) begin c0 = 8'hD1; c1 = 8'h86; end
                else if (nl == "h" && lc == "k") begin c0 = 8'hD1; c1 = 8'h85; end
                else if (nl == "h" && lc == "g") begin c0 = 8'hD0; c1 = 8'hB3; end
                else if (nl == "h" && lc == "z") begin c0 = 8'hD0; c1 = 8'hB6; end
                else if (nl == "h" && lc == "c") begin c0 = 8'hD1; c1 = 8'h87; end
                else if (nl == "h" && lc == "s") begin c0 = 8'hD1; c1 = 8'h88; end
                else if (lc == "o" && nl == "o") begin c0 = 8'hD1; c1 = 8'h83; end
                else if (lc == "e" && nl == "e") begin c0 = 8'hD0; c1 = 8'hB8; end
                if (c0 != 8'h00) begin
                    emit_letter(c0, c1, up);
                    si += 2;
                    continue;
                end
            end
            if (lc == "o" || lc == "g") begin
                ap = apos_at(si + 1, n);
                if (ap != 0) begin
                    if (lc == "o") emit_letter(8'hD1, 8'h83, up);
                    else emit_letter(8'hD0, 8'hB3, up);
                    si += 1 + ap;
                    continue;
                end
            end
            sm = SINGLE_TBL[lc - "a"];
            emit_letter(sm[15:8], sm[7:0], up);
            if (lc == "j" || lc == "x") begin
                up2 = up && si + 1 < n && up_letter(win_bytes[si + 1]);
                if (lc == "j") emit_letter(8'hD0, 8'hB6, up2);
                else emit_letter(8'hD1, 8'h81, up2);
            end
            si++;
        end
        if (si > n) si = n;
        for (k = 0; k < n - si; k++) win_bytes[k] = win_bytes[k + si];
        win_fill = n - si;
        tok_stop = tok_stop > si ? tok_stop - si : 0;
        if (tok_start < si) begin
            start_gone = 1'b1;
            tok_start  = 0;
        end else begin
            tok_start -= si;
        end
    endtask

    task automatic predict_units(input logic [7:0] b, input bit ended);
        int k;
        step_units.delete();
        if (win_fill < WIN_MAX) begin
            win_bytes[win_fill] = b;
            win_fill++;
        end
        translate_window(ended);
        if (ended && step_units.size() == 0) emit(8'h00, 8'h00, CNT_EMPTY);
        if (step_units.size() > 0) begin
            for (k = 0; k < step_units.size(); k++) step_units[k].token_overflow = ovf_pending;
            ovf_pending = 1'b0;
            step_units[step_units.size() - 1].run_end = 1'b1;
            if (ended) step_units[step_units.size() - 1].string_done = 1'b1;
        end
        foreach (step_units[k]) exp_units.push_back(step_units[k]);
        if (ended) clear_model();
    endtask

    always @(posedge i_clk) begin
        t_unit e;
        if (!i_rst_n) begin
            clear_model();
            exp_units.delete();
            fails = 0;
        end else begin
            if (i_in.valid && i_in.ready) predict_units(i_in.in_byte, i_in.string_end);
            if (i_out.valid && i_out.ready) begin
                if (exp_units.size() == 0) begin
                    $error("unexpected unit %h %h cnt %0d", i_out.first_byte,
                           i_out.second_byte, i_out.byte_count);
                    fails++;
                end else begin
                    e = exp_units.pop_front();
                    if (i_out.first_byte !== e.first_byte) begin
                        $error("first_byte: expected %h, got %h", e.first_byte, i_out.first_byte);
                        fails++;
                    end
                    if (i_out.second_byte !== e.second_byte) begin
                        $error("second_byte: expected %h, got %h", e.second_byte,
                               i_out.second_byte);
                        fails++;
                    end
                    if (i_out.byte_count !== e.byte_count) begin
                        $error("byte_count: expected %0d, got %0d", e.byte_count,
                               i_out.byte_count);
                        fails++;
                    end
                    if (i_out.run_end !== e.run_end) begin
                        $error("run_end: expected %b, got %b", e.run_end, i_out.run_end);
                        fails++;
                    end
                    if (i_out.string_done !== e.string_done) begin
                        $error("string_done: expected %b, got %b", e.string_done,
                               i_out.string_done);
                        fails++;
                    end
                    if (i_out.token_overflow !== e.token_overflow) begin
                        $error("token_overflow: expected %b, got %b", e.token_overflow,
                               i_out.token_overflow);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= exp_units.size();
    end

endmodule

// ----- sim/latin_to_cyrillic_transliterator_core_tb.sv -----
// Testbench top: drives name strings into the transliterator and gives the verdict.
module latin_to_cyrillic_transliterator_core_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int NUM_ITEMS   = 175;

    logic i_clk;
    logic i_rst_n;
    int   cycles = 0;
    int   fail_count;
    int   pending;
    int   rx_units;
    logic [8:0] byte_q [$];

    l2c_in_if  in_ch ();
    l2c_out_if out_ch ();

    latin_to_cyrillic_transliterator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    l2c_tb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) byte_q.push_back({1'b0, s[k]});
    endtask

    task automatic add_byte(input logic [7:0] b);
        byte_q.push_back({1'b0, b});
    endtask

    task automatic close_string();
        byte_q[byte_q.size() - 1][8] = 1'b1;
    endtask

    task automatic add_random_string();
        string      twins;
        string      pairs;
        int         pieces;
        int         sel;
        int         k;
        int         m;
        logic [7:0] lead;
        logic [7:0] b;
        twins  = "aceokmpxyBCEHKMOPTXY";
        pairs  = "yayuyoyetskhghzhchshooeeYaTsKhSh";
        pieces = $urandom_range(1, 10);
        for (k = 0; k < pieces; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                b = 8'h61 + 8'($urandom_range(0, 25));
                if ($urandom_range(0, 2) == 0) b = b - 8'h20;
                add_byte(b);
            end else if (sel < 50) begin
                add_byte(twins[$urandom_range(0, twins.len() - 1)]);
            end else if (sel < 65) begin
                lead = 8'hD0 + 8'($urandom_range(0, 3));
                add_byte(lead);
                add_byte(8'h80 + 8'($urandom_range(0, 63)));
            end else if (sel < 73) begin
                case ($urandom_range(0, 4))
                    0: add_byte(8'h27);
                    1: begin add_byte(8'hCA); add_byte(8'hBB); end
                    2: begin add_byte(8'hCA); add_byte(8'hBC); end
                    3: begin add_byte(8'hE2); add_byte(8'h80); add_byte(8'h98); end
                    default: begin add_byte(8'hE2); add_byte(8'h80); add_byte(8'h99); end
                endcase
            end else if (sel < 83) begin
                add_byte($urandom_range(0, 1) ? 8'h20 : 8'h2D);
            end else if (sel < 90) begin
                m = 2 * $urandom_range(0, pairs.len() / 2 - 1);
                add_byte(pairs[m]);
                add_byte(pairs[m + 1]);
            end else if (sel < 95) begin
                add_byte(8'($urandom_range(0, 255)));
            end else begin
                // long run that forces the token cut
                m = $urandom_range(18, 40);
                repeat (m) add_byte(8'h61 + 8'($urandom_range(0, 25)));
            end
        end
        close_string();
    endtask

    // Receiver: random back-pressure plus one long hold-off that stalls the block.
    initial begin
        int gap;
        rx_units = 0;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_units == 30) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                rx_units++;
            end
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            rx_units++;
        end
    end

    initial begin
        int         gap;
        logic [8:0] item;
        in_ch.valid       = 1'b0;
        in_ch.in_byte     = 8'h00;
        in_ch.string_end  = 1'b0;
        i_rst_n           = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: initial x, j, o-apostrophe, digraphs, ts before h, apostrophe forms
        add_text("Xo'j"); close_string();
        add_text("Yakhtsh"); close_string();
        add_byte(8'hD1); add_byte(8'h81); add_text("a g"); add_byte(8'hCA); add_byte(8'hBC);
        add_text("ee"); close_string();
        add_byte(8'h27); close_string();
        add_byte(8'hD0); close_string();
        add_byte(8'h00); add_byte(8'hFF); close_string();
        while (byte_q.size() < NUM_ITEMS) add_random_string();

        while (byte_q.size() > 0) begin
            item = byte_q.pop_front();
            gap  = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_ch.valid      <= 1'b1;
            in_ch.in_byte    <= item[7:0];
            in_ch.string_end <= item[8];
            do @(posedge i_clk); while (!in_ch.ready);
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
